>>> hw/rtl/dual_weight_shortest_path_macros.svh
// assertion helpers used by the engine
`ifndef DUAL_WEIGHT_SHORTEST_PATH_MACROS_SVH
`define DUAL_WEIGHT_SHORTEST_PATH_MACROS_SVH

// same-cycle implication, checked out of reset
`define DWSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwsp assertion failed");

// next-cycle implication, checked out of reset
`define DWSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwsp assertion failed");

`endif

>>> hw/rtl/dwsp_pkg.sv
`default_nettype none
package dwsp_pkg;

    localparam int ID_W          = 6;
    localparam int WT_W          = 16;
    localparam int SUM_W         = 24;
    localparam int CNT_W         = 7;
    localparam int EDGE_W        = 2 * ID_W + 2 * WT_W;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic [SUM_W-1:0] SAT_MAX        = 24'hFFFFFF;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_PATH   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_NOPATH = 2'd3;

    localparam logic [1:0] FLAG_REACHED = 2'b01;
    localparam logic [1:0] FLAG_DONE    = 2'b10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESP,
        S_INIT,
        S_SCAN,
        S_EXTRACT,
        S_EDGE,
        S_NODE,
        S_END_RD,
        S_END_CHK,
        S_WALK,
        S_SEARCH,
        S_EMIT_RD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] edge_from;
        logic [ID_W-1:0] edge_to;
        logic [WT_W-1:0] edge_distance;
        logic [WT_W-1:0] edge_cost;
        logic [ID_W-1:0] start_node;
        logic [ID_W-1:0] end_node;
        logic            use_traffic_cost;
    } item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  path_node;
        logic             last;
        logic             found;
        logic [SUM_W-1:0] total_distance;
        logic [SUM_W-1:0] total_cost;
    } res_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [WT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W-WT_W+1){1'b0}}, b};
        return s[SUM_W] ? SAT_MAX : s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dwsp_if.sv
`default_nettype none
interface dwsp_req_if;
    import dwsp_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dwsp_rsp_if;
    import dwsp_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dual_weight_shortest_path.sv
`default_nettype none
// shortest path engine over a stored list of directed edges. an add word
// appends an edge (from, to, distance, traffic cost in unsigned 12.4), a
// clear word empties the list, and each of these answers with one word. a
// query word runs dijkstra from start to end, weighing edges by distance or
// by traffic cost, and returns the path one node per word with last on the
// end node; every path word carries the path totals, which saturate at 24
// bits. a bad endpoint or an unreachable end gives a single no-path word.
// the node table, the edge list and the path buffer live in three synchronous
// rams with one read and one write port each, so one item is worked on at a
// time. clear and add pass through the idle state and a response state. a
// query first initialises the node table, then for every extracted node
// scans the node table, extracts the closest node and reads each stored
// edge, with a node step per relaxed edge; then per path node it takes a
// walk step and an edge search of up to the edge count, then a read step
// and an emit step per emitted word, holding while the output is stalled.
// there is no clearing pass after reset. node_count may only be rewritten
// while the block is idle.
module dual_weight_shortest_path #(
    parameter int MAX_NODES = dwsp_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = dwsp_pkg::DEF_MAX_EDGES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    dwsp_req_if.sink                        req,
    dwsp_rsp_if.source                      rsp,
    input  wire logic                       node_count_we,
    input  wire logic [dwsp_pkg::CNT_W-1:0] node_count_wdata
);
    import dwsp_pkg::*;

    // node count register
    logic [CNT_W-1:0] node_count_reg;

    // output word register, parts the engine from the consumer
    logic out_valid_reg, out_valid_next;
    res_t out_data_reg, out_data_next;

    logic out_free;
    logic push;
    res_t result;

    dwsp_engine #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (req.data),
        .item_valid (req.valid),
        .item_ready (req.ready),
        .node_count (node_count_reg),
        .out_free   (out_free),
        .push       (push),
        .result     (result)
    );

    // a slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (node_count_we)
            begin
                node_count_reg <= node_count_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end
endmodule
`default_nettype wire

>>> hw/rtl/dwsp_ram.sv
`default_nettype none
module dwsp_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
    input  wire logic [W-1:0]                      wdata,
    input  wire logic                              re,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
    output logic      [W-1:0]                      rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/dwsp_engine.sv
`default_nettype none
`include "dual_weight_shortest_path_macros.svh"
module dwsp_engine #(
    parameter int MAX_NODES = dwsp_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = dwsp_pkg::DEF_MAX_EDGES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dwsp_pkg::item_t            item,
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire logic [dwsp_pkg::CNT_W-1:0] node_count,
    input  wire logic                       out_free,
    output logic                            push,
    output dwsp_pkg::res_t                  result
);
    import dwsp_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int PW  = $clog2(MAX_NODES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int NEW = SUM_W + PW + 2;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [ID_W-1:0]  rd_idx_reg, rd_idx_next;
    logic             best_valid_reg, best_valid_next;
    logic [ID_W-1:0]  best_idx_reg, best_idx_next;
    logic [NEW-1:0]   best_ent_reg, best_ent_next;
    logic [CW-1:0]    edge_idx_reg, edge_idx_next;
    logic [CW-1:0]    edge_total_reg, edge_total_next;
    logic [ID_W-1:0]  s_reg, s_next;
    logic [ID_W-1:0]  e_reg, e_next;
    logic             by_cost_reg, by_cost_next;
    logic [1:0]       resp_status_reg, resp_status_next;
    logic [ID_W-1:0]  cur_reg, cur_next;
    logic [ID_W-1:0]  par_reg, par_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [SUM_W-1:0] td_reg, td_next;
    logic [SUM_W-1:0] tc_reg, tc_next;

    // memory ports
    logic              edge_we, edge_re;
    logic [EW-1:0]     edge_waddr, edge_raddr;
    logic [EDGE_W-1:0] edge_wdata, edge_rd;
    logic              node_we, node_re;
    logic [NW-1:0]     node_waddr, node_raddr;
    logic [NEW-1:0]    node_wdata, node_rd;
    logic              pb_we, pb_re;
    logic [NW-1:0]     pb_waddr, pb_raddr;
    logic [ID_W-1:0]   pb_wdata, pb_rd;

    dwsp_ram #(.W(EDGE_W), .D(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .re(edge_re), .raddr(edge_raddr), .rdata(edge_rd)
    );
    dwsp_ram #(.W(NEW), .D(MAX_NODES)) u_node_ram (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(node_rd)
    );
    dwsp_ram #(.W(ID_W), .D(MAX_NODES)) u_path_ram (
        .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
        .re(pb_re), .raddr(pb_raddr), .rdata(pb_rd)
    );

    // shared decode
    logic [CNT_W-1:0] n_eff;
    logic             accept, q_ok, add_ok;
    logic [ID_W-1:0]  e_from, e_to;
    logic [WT_W-1:0]  e_dist, e_cost, w;
    logic [SUM_W-1:0] nd_dist, nd_new, best_dist;
    logic [PW-1:0]    nd_par;
    logic [1:0]       nd_flags;
    logic             scan_more, edge_more, relax_hit, upd, walk_go, search_hit;
    logic             last_emit;
    logic [CNT_W-1:0] walk_p;
    logic [CNT_W-1:0] pb_pos;

    assign n_eff     = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
    assign accept    = item_valid && item_ready;
    assign q_ok      = ({1'b0, item.start_node} < n_eff) && ({1'b0, item.end_node} < n_eff);
    assign add_ok    = (edge_total_reg < CW'(MAX_EDGES)) && ({1'b0, item.edge_from} < n_eff)
                       && ({1'b0, item.edge_to} < n_eff);
    assign e_from    = edge_rd[EDGE_W-1 -: ID_W];
    assign e_to      = edge_rd[2*WT_W +: ID_W];
    assign e_dist    = edge_rd[WT_W +: WT_W];
    assign e_cost    = edge_rd[WT_W-1:0];
    assign w         = by_cost_reg ? e_cost : e_dist;
    assign nd_dist   = node_rd[SUM_W-1:0];
    assign nd_par    = node_rd[SUM_W +: PW];
    assign nd_flags  = node_rd[NEW-1 -: 2];
    assign best_dist = best_ent_reg[SUM_W-1:0];
    assign nd_new    = sat_add(best_dist, w);
    assign scan_more = idx_reg < n_eff;
    assign edge_more = ({1'b0, edge_idx_reg} + (CW+1)'(1)) < {1'b0, edge_total_reg};
    assign relax_hit = (e_from == best_idx_reg) && ({1'b0, e_to} < n_eff);
    assign upd       = !nd_flags[0] || (nd_new < nd_dist);
    assign walk_p    = CNT_W'(nd_par);
    assign walk_go   = (walk_p < n_eff) && ((len_reg + CNT_W'(1)) < n_eff);
    assign search_hit = (e_from == par_reg) && (e_to == cur_reg);
    assign last_emit = (idx_reg + CNT_W'(1)) == len_reg;
    assign pb_pos    = len_reg - CNT_W'(1) - idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.operation == OP_QUERY && q_ok) ? S_INIT : S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_INIT:
            begin
                if ((idx_reg + CNT_W'(1)) >= n_eff)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!scan_more && !rd_valid_reg)
                begin
                    state_next = S_EXTRACT;
                end
            end
            S_EXTRACT:
            begin
                if (!best_valid_reg || best_idx_reg == e_reg)
                begin
                    state_next = S_END_RD;
                end
                else if (edge_total_reg == '0)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (relax_hit)
                begin
                    state_next = S_NODE;
                end
                else if (!edge_more)
                begin
                    state_next = S_SCAN;
                end
            end
            S_NODE:
            begin
                state_next = edge_more ? S_EDGE : S_SCAN;
            end
            S_END_RD:
            begin
                state_next = S_END_CHK;
            end
            S_END_CHK:
            begin
                state_next = nd_flags[0] ? S_WALK : S_RESP;
            end
            S_WALK:
            begin
                state_next = walk_go ? S_SEARCH : S_EMIT_RD;
            end
            S_SEARCH:
            begin
                if (search_hit || !edge_more)
                begin
                    state_next = S_WALK;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_emit ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next         = idx_reg;
        rd_valid_next    = rd_valid_reg;
        rd_idx_next      = rd_idx_reg;
        best_valid_next  = best_valid_reg;
        best_idx_next    = best_idx_reg;
        best_ent_next    = best_ent_reg;
        edge_idx_next    = edge_idx_reg;
        edge_total_next  = edge_total_reg;
        s_next           = s_reg;
        e_next           = e_reg;
        by_cost_next     = by_cost_reg;
        resp_status_next = resp_status_reg;
        cur_next         = cur_reg;
        par_next         = par_reg;
        len_next         = len_reg;
        td_next          = td_reg;
        tc_next          = tc_reg;
        edge_we    = 1'b0;
        edge_waddr = edge_total_reg[EW-1:0];
        edge_wdata = {item.edge_from, item.edge_to, item.edge_distance, item.edge_cost};
        edge_re    = 1'b0;
        edge_raddr = '0;
        node_we    = 1'b0;
        node_waddr = cur_reg[NW-1:0];
        node_wdata = {nd_flags | FLAG_REACHED, PW'(best_idx_reg), nd_new};
        node_re    = 1'b0;
        node_raddr = idx_reg[NW-1:0];
        pb_we      = 1'b0;
        pb_waddr   = len_reg[NW-1:0];
        pb_wdata   = cur_reg;
        pb_re      = 1'b0;
        pb_raddr   = pb_pos[NW-1:0];
        item_ready = 1'b0;
        push       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (accept)
                begin
                    s_next       = item.start_node;
                    e_next       = item.end_node;
                    by_cost_next = item.use_traffic_cost;
                    idx_next     = '0;
                    case (item.operation)
                        OP_CLEAR:
                        begin
                            edge_total_next  = '0;
                            resp_status_next = ST_ACCEPT;
                        end
                        OP_ADD:
                        begin
                            if (add_ok)
                            begin
                                edge_we          = 1'b1;
                                edge_total_next  = edge_total_reg + CW'(1);
                                resp_status_next = ST_ACCEPT;
                            end
                            else
                            begin
                                resp_status_next = ST_REJECT;
                            end
                        end
                        OP_QUERY:
                        begin
                            resp_status_next = ST_NOPATH;
                        end
                        default:
                        begin
                            resp_status_next = ST_REJECT;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                push = out_free;
            end
            S_INIT:
            begin
                node_we    = 1'b1;
                node_waddr = idx_reg[NW-1:0];
                node_wdata = {(idx_reg[ID_W-1:0] == s_reg) ? FLAG_REACHED : 2'b00,
                              PW'(MAX_NODES), {SUM_W{1'b0}}};
                idx_next   = idx_reg + CNT_W'(1);
            end
            S_SCAN:
            begin
                if (scan_more)
                begin
                    node_re       = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = idx_reg[ID_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    rd_valid_next = 1'b0;
                end
                if (rd_valid_reg && nd_flags == FLAG_REACHED
                    && (!best_valid_reg || nd_dist < best_dist))
                begin
                    best_valid_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_ent_next   = node_rd;
                end
            end
            S_EXTRACT:
            begin
                if (best_valid_reg)
                begin
                    node_we       = 1'b1;
                    node_waddr    = best_idx_reg[NW-1:0];
                    node_wdata    = best_ent_reg | {FLAG_DONE, {(NEW-2){1'b0}}};
                    edge_re       = 1'b1;
                    edge_idx_next = '0;
                end
            end
            S_EDGE:
            begin
                if (relax_hit)
                begin
                    node_re    = 1'b1;
                    node_raddr = e_to[NW-1:0];
                    cur_next   = e_to;
                end
                else if (edge_more)
                begin
                    edge_re       = 1'b1;
                    edge_idx_next = edge_idx_reg + CW'(1);
                    edge_raddr    = edge_idx_next[EW-1:0];
                end
            end
            S_NODE:
            begin
                node_we = upd;
                if (edge_more)
                begin
                    edge_re       = 1'b1;
                    edge_idx_next = edge_idx_reg + CW'(1);
                    edge_raddr    = edge_idx_next[EW-1:0];
                end
            end
            S_END_RD:
            begin
                node_re    = 1'b1;
                node_raddr = e_reg[NW-1:0];
            end
            S_END_CHK:
            begin
                cur_next = e_reg;
                len_next = '0;
                td_next  = '0;
                tc_next  = '0;
            end
            S_WALK:
            begin
                pb_we    = 1'b1;
                len_next = len_reg + CNT_W'(1);
                idx_next = '0;
                if (walk_go)
                begin
                    par_next      = walk_p[ID_W-1:0];
                    edge_re       = 1'b1;
                    edge_idx_next = '0;
                end
            end
            S_SEARCH:
            begin
                if (search_hit)
                begin
                    td_next = sat_add(td_reg, e_dist);
                    tc_next = sat_add(tc_reg, e_cost);
                end
                if (search_hit || !edge_more)
                begin
                    node_re    = 1'b1;
                    node_raddr = par_reg[NW-1:0];
                    cur_next   = par_reg;
                end
                else
                begin
                    edge_re       = 1'b1;
                    edge_idx_next = edge_idx_reg + CW'(1);
                    edge_raddr    = edge_idx_next[EW-1:0];
                end
            end
            S_EMIT_RD:
            begin
                pb_re = 1'b1;
            end
            S_EMIT:
            begin
                push = out_free;
                if (out_free)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        // fresh extraction pass
        if (state_next == S_SCAN && state_reg != S_SCAN)
        begin
            idx_next        = '0;
            rd_valid_next   = 1'b0;
            best_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        if (state_reg == S_EMIT)
        begin
            result.status         = ST_PATH;
            result.path_node      = pb_rd;
            result.last           = last_emit;
            result.found          = 1'b1;
            result.total_distance = td_reg;
            result.total_cost     = tc_reg;
        end
        else
        begin
            result.status         = resp_status_reg;
            result.path_node      = '0;
            result.last           = 1'b1;
            result.found          = 1'b0;
            result.total_distance = '0;
            result.total_cost     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_total_reg <= '0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            rd_valid_reg   <= rd_valid_next;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        rd_idx_reg      <= rd_idx_next;
        best_idx_reg    <= best_idx_next;
        best_ent_reg    <= best_ent_next;
        edge_idx_reg    <= edge_idx_next;
        s_reg           <= s_next;
        e_reg           <= e_next;
        by_cost_reg     <= by_cost_next;
        resp_status_reg <= resp_status_next;
        cur_reg         <= cur_next;
        par_reg         <= par_next;
        len_reg         <= len_next;
        td_reg          <= td_next;
        tc_reg          <= tc_next;
    end

    `DWSP_ASSERT_IMP(a_push_room, push, out_free)
    `DWSP_ASSERT_IMP(a_edge_bound, 1'b1, edge_total_reg <= CW'(MAX_EDGES))
    `DWSP_ASSERT_NEXT(a_query_start, accept && item.operation == OP_QUERY && q_ok,
                      state_reg == S_INIT)
endmodule
`default_nettype wire
